@@ rtl/pcp_pkg.sv @@
`default_nettype none

package pcp_pkg;

	// result kinds, carried on m_tuser
	typedef enum logic [2:0] {
		KIND_DATA       = 3'd0,
		KIND_HEADER     = 3'd1,
		KIND_END        = 3'd2,
		KIND_BAD_SIG    = 3'd3,
		KIND_BAD_LENGTH = 3'd4
	} result_kind_t;

	// chunk type tags, big-endian ascii
	localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
	localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
	localparam logic [31:0] TAG_IEND = 32'h4945_4E44;

	localparam logic [7:0] COLOR_RGB  = 8'd2;
	localparam logic [7:0] COLOR_RGBA = 8'd6;

	// packed widths of the result stream
	localparam int unsigned RES_BITS   = 117;
	localparam int unsigned TDATA_BITS = 120;

	typedef struct packed {
		logic [6:0]  bytes_per_pixel;
		logic [7:0]  interlace_method;
		logic [7:0]  filter_method;
		logic [7:0]  compression_method;
		logic [7:0]  color_code;
		logic [7:0]  sample_depth;
		logic [30:0] image_height;
		logic [30:0] image_width;
		logic [7:0]  data_byte;
	} result_data_t;

	typedef struct packed {
		result_kind_t kind;
		result_data_t data;
	} result_t;

	// eight-byte file signature
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'd137;
			3'd1: b = 8'd80;
			3'd2: b = 8'd78;
			3'd3: b = 8'd71;
			3'd4: b = 8'd13;
			3'd5: b = 8'd10;
			3'd6: b = 8'd26;
			3'd7: b = 8'd10;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	// bytes per pixel for 8-bit-aligned truecolor formats
	function automatic logic [6:0] calc_bpp(input logic [7:0] depth, input logic [7:0] ctype);
		logic [9:0] x3;
		logic [6:0] r;
		x3 = {2'b00, depth} + {1'b0, depth, 1'b0};
		if (ctype == COLOR_RGB) begin
			r = x3[9:3];
		end else if (ctype == COLOR_RGBA) begin
			r = depth[7:1];
		end else begin
			r = 7'd0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/png_chunk_parser_top.sv @@
`default_nettype none

// PNG chunk stream parser. Takes a PNG file one byte per request on the s_ side
// and produces at most one result per byte on the m_ side: each IDAT body byte as
// a data result, a header result carrying the IHDR fields and bytes per pixel once
// the IHDR chunk's CRC has gone by, an end result on the IEND type, or an error on
// a bad signature or a chunk length with its top bit set. CRCs are skipped, not
// checked. After end or error every byte is taken and dropped until reset.
// One byte is taken every cycle while s_tready is high; the parse state updates at
// the accepting edge and the result lands in an output register backed by a
// one-entry skid buffer, so s_tready only drops when both are full (a stalled
// m_tready for two results).

module png_chunk_parser_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // byte_in
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// data_byte, image_width, image_height, sample_depth, color_code,
	// compression_method, filter_method, interlace_method, bytes_per_pixel, zero pad
	output logic [pcp_pkg::TDATA_BITS-1:0] m_tdata,
	output logic [2:0]        m_tuser    // result_kind
);

	typedef enum logic [2:0] {
		PH_SIG,
		PH_LEN,
		PH_TYPE,
		PH_BODY,
		PH_CRC,
		PH_DONE,
		PH_HALT
	} phase_t;

	// parse state
	phase_t       phase_q, phase_d;
	logic [2:0]   sig_idx_q, sig_idx_d;
	logic [30:0]  pos_q, pos_d;
	logic [30:0]  len_q, len_d;
	logic [31:0]  tag_q, tag_d;
	logic [30:0]  width_q, width_d;
	logic [30:0]  height_q, height_d;
	logic [7:0]   hdr_q [5];
	logic [7:0]   hdr_d [5];

	// result staging
	pcp_pkg::result_t res;
	logic             res_valid;
	pcp_pkg::result_t out_q;
	logic             out_valid_q;
	pcp_pkg::result_t skid_q;
	logic             skid_valid_q;

	logic        accept;
	logic        out_free;
	logic [7:0]  b;
	logic [31:0] pos_inc;
	logic        body_last;

	assign b        = s_tdata;
	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign pos_inc   = {1'b0, pos_q} + 32'd1;
	assign body_last = pos_inc >= {1'b0, len_q};

	always_comb begin
		phase_d   = phase_q;
		sig_idx_d = sig_idx_q;
		pos_d     = pos_q;
		len_d     = len_q;
		tag_d     = tag_q;
		width_d   = width_q;
		height_d  = height_q;
		hdr_d     = hdr_q;
		res_valid = 1'b0;
		res       = '0;

		case (phase_q)
			PH_SIG: begin
				if (b != pcp_pkg::sig_byte(sig_idx_q)) begin
					phase_d   = PH_HALT;
					res_valid = 1'b1;
					res.kind  = pcp_pkg::KIND_BAD_SIG;
				end else if (sig_idx_q == 3'd7) begin
					sig_idx_d = 3'd0;
					pos_d     = '0;
					phase_d   = PH_LEN;
				end else begin
					sig_idx_d = sig_idx_q + 3'd1;
				end
			end
			PH_LEN: begin
				if (pos_q == '0 && b[7]) begin
					phase_d   = PH_HALT;
					res_valid = 1'b1;
					res.kind  = pcp_pkg::KIND_BAD_LENGTH;
				end else begin
					len_d = {len_q[22:0], b};
					if (pos_q == 31'd3) begin
						pos_d   = '0;
						phase_d = PH_TYPE;
					end else begin
						pos_d = pos_inc[30:0];
					end
				end
			end
			PH_TYPE: begin
				tag_d = {tag_q[23:0], b};
				if (pos_q == 31'd3) begin
					pos_d = '0;
					if (tag_d == pcp_pkg::TAG_IEND) begin
						phase_d   = PH_DONE;
						res_valid = 1'b1;
						res.kind  = pcp_pkg::KIND_END;
					end else begin
						// a new IHDR starts from cleared fields
						if (tag_d == pcp_pkg::TAG_IHDR) begin
							width_d  = '0;
							height_d = '0;
							for (int i = 0; i < 5; i++) begin
								hdr_d[i] = '0;
							end
						end
						phase_d = (len_q == '0) ? PH_CRC : PH_BODY;
					end
				end else begin
					pos_d = pos_inc[30:0];
				end
			end
			PH_BODY: begin
				if (tag_q == pcp_pkg::TAG_IHDR) begin
					if (pos_q < 31'd4) begin
						width_d = {width_q[22:0], b};
					end else if (pos_q < 31'd8) begin
						height_d = {height_q[22:0], b};
					end else if (pos_q < 31'd13) begin
						case (pos_q[2:0])
							3'd0: hdr_d[0] = b;
							3'd1: hdr_d[1] = b;
							3'd2: hdr_d[2] = b;
							3'd3: hdr_d[3] = b;
							3'd4: hdr_d[4] = b;
							default: hdr_d[0] = hdr_q[0];
						endcase
					end
				end else if (tag_q == pcp_pkg::TAG_IDAT) begin
					res_valid          = 1'b1;
					res.kind           = pcp_pkg::KIND_DATA;
					res.data.data_byte = b;
				end
				if (body_last) begin
					pos_d   = '0;
					phase_d = PH_CRC;
				end else begin
					pos_d = pos_inc[30:0];
				end
			end
			PH_CRC: begin
				if (pos_q == 31'd3) begin
					pos_d   = '0;
					phase_d = PH_LEN;
					if (tag_q == pcp_pkg::TAG_IHDR) begin
						res_valid                   = 1'b1;
						res.kind                    = pcp_pkg::KIND_HEADER;
						res.data.image_width        = width_q;
						res.data.image_height       = height_q;
						res.data.sample_depth       = hdr_q[0];
						res.data.color_code         = hdr_q[1];
						res.data.compression_method = hdr_q[2];
						res.data.filter_method      = hdr_q[3];
						res.data.interlace_method   = hdr_q[4];
						res.data.bytes_per_pixel    = pcp_pkg::calc_bpp(hdr_q[0], hdr_q[1]);
					end
				end else begin
					pos_d = pos_inc[30:0];
				end
			end
			default: begin
				// done or halted: bytes are swallowed
				phase_d = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SIG;
			sig_idx_q    <= '0;
			pos_q        <= '0;
			len_q        <= '0;
			tag_q        <= '0;
			width_q      <= '0;
			height_q     <= '0;
			for (int i = 0; i < 5; i++) begin
				hdr_q[i] <= '0;
			end
			out_q        <= '0;
			out_valid_q  <= 1'b0;
			skid_q       <= '0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q   <= phase_d;
				sig_idx_q <= sig_idx_d;
				pos_q     <= pos_d;
				len_q     <= len_d;
				tag_q     <= tag_d;
				width_q   <= width_d;
				height_q  <= height_d;
				hdr_q     <= hdr_d;
			end
			// output register drains the skid first; skid only fills on a stall
			if (out_free) begin
				if (skid_valid_q) begin
					out_q        <= skid_q;
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_q       <= res;
					out_valid_q <= accept && res_valid;
				end
			end else if (accept && res_valid) begin
				skid_q       <= res;
				skid_valid_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {{(pcp_pkg::TDATA_BITS - pcp_pkg::RES_BITS){1'b0}}, out_q.data};

endmodule

`default_nettype wire

@@ rtl/pcp_checker.sv @@
`default_nettype none

module pcp_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic [7:0]   s_tdata,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [119:0] m_tdata,
	input wire logic [2:0]   m_tuser
);

	// set once an end or error result has been taken
	logic final_q;
	logic in_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_q   <= 1'b0;
			in_seen_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && (m_tuser == pcp_pkg::KIND_END ||
					m_tuser == pcp_pkg::KIND_BAD_SIG || m_tuser == pcp_pkg::KIND_BAD_LENGTH)) begin
				final_q <= 1'b1;
			end
			if (s_tvalid && s_tready && s_tdata != 8'd0) begin
				in_seen_q <= 1'b1;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_nothing_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		final_q |-> !m_tvalid)
		else $error("result after end or error");

	a_header_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != pcp_pkg::KIND_HEADER |-> m_tdata[116:8] == '0)
		else $error("header fields set on a non-header result");

	a_data_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != pcp_pkg::KIND_DATA |-> m_tdata[7:0] == 8'd0)
		else $error("data byte set on a non-data result");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_seen_q && m_tvalid |-> m_tuser == pcp_pkg::KIND_BAD_SIG)
		else $error("result before any nonzero byte other than bad signature");

endmodule

bind png_chunk_parser_top pcp_checker u_pcp_checker (.*);

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

	// parse phases of the byte walker
	typedef enum logic [2:0] {
		PH_SIG,
		PH_LEN,
		PH_TYPE,
		PH_BODY,
		PH_CRC,
		PH_DONE,
		PH_HALT
	} parse_phase_t;

	// one row of the directed table: a byte and, where obvious, its result
	typedef struct packed {
		logic [7:0]       value;
		logic             typed;
		pcp_pkg::result_t want;
	} stim_row_t;

	localparam logic [7:0] PNG_MAGIC [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
		8'd13, 8'd10, 8'd26, 8'd10};
	localparam int unsigned RANDOM_BYTES = 750;
	localparam int unsigned MAX_REPORTS = 10;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'd0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic [2:0]   m_tuser;

	// own copy of the parser state
	parse_phase_t parse_phase;
	logic [2:0]   sig_index;
	int unsigned  byte_pos;
	logic [30:0]  chunk_len;
	logic [31:0]  chunk_tag;
	logic [30:0]  hdr_width;
	logic [30:0]  hdr_height;
	logic [39:0]  hdr_bytes;

	pcp_pkg::result_t results_due [$];
	stim_row_t        directed [$];

	int unsigned  bytes_sent = 0;
	int unsigned  bad_results = 0;
	int unsigned  kind_seen [5] = '{0, 0, 0, 0, 0};
	int unsigned  stall_left = 0;
	int unsigned  rx_cycles = 0;
	bit           sender_calm = 1'b0;
	bit           ended_by_error = 1'b0;

	png_chunk_parser_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one, none in a calm stretch
	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		r = $urandom_range(99);
		if (calm || r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 2);
		end else if (r < 97) begin
			return $urandom_range(3, 6);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic string fmt_result(input pcp_pkg::result_t r);
		return $sformatf({"kind %0d data %02h w %0d h %0d depth %0d ctype %0d",
			" cm %0d fm %0d im %0d bpp %0d"},
			r.kind, r.data.data_byte, r.data.image_width, r.data.image_height,
			r.data.sample_depth, r.data.color_code, r.data.compression_method,
			r.data.filter_method, r.data.interlace_method, r.data.bytes_per_pixel);
	endfunction

	// walk one byte through the chunk grammar, returns 1 when it makes a result
	function automatic bit parse_byte(input logic [7:0] b, output pcp_pkg::result_t r);
		bit          produced;
		int unsigned depth;
		int unsigned bpp;
		produced = 1'b0;
		r = '0;
		r.kind = pcp_pkg::KIND_DATA;
		case (parse_phase)
			PH_SIG: begin
				if (b != PNG_MAGIC[sig_index]) begin
					parse_phase = PH_HALT;
					r.kind = pcp_pkg::KIND_BAD_SIG;
					produced = 1'b1;
				end else if (sig_index == 3'd7) begin
					sig_index = 3'd0;
					byte_pos = 0;
					parse_phase = PH_LEN;
				end else begin
					sig_index = sig_index + 3'd1;
				end
			end
			PH_LEN: begin
				// length above 2^31-1 shows on the top bit of the first byte
				if (byte_pos == 0 && b[7]) begin
					parse_phase = PH_HALT;
					r.kind = pcp_pkg::KIND_BAD_LENGTH;
					produced = 1'b1;
				end else begin
					chunk_len = {chunk_len[22:0], b};
					byte_pos++;
					if (byte_pos >= 4) begin
						byte_pos = 0;
						parse_phase = PH_TYPE;
					end
				end
			end
			PH_TYPE: begin
				chunk_tag = {chunk_tag[23:0], b};
				byte_pos++;
				if (byte_pos >= 4) begin
					byte_pos = 0;
					if (chunk_tag == pcp_pkg::TAG_IEND) begin
						parse_phase = PH_DONE;
						r.kind = pcp_pkg::KIND_END;
						produced = 1'b1;
					end else begin
						// a fresh header starts from zero, so a short body reads as zeros
						if (chunk_tag == pcp_pkg::TAG_IHDR) begin
							hdr_width = '0;
							hdr_height = '0;
							hdr_bytes = '0;
						end
						parse_phase = (chunk_len == 0) ? PH_CRC : PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (chunk_tag == pcp_pkg::TAG_IHDR) begin
					if (byte_pos < 4) begin
						hdr_width = {hdr_width[22:0], b};
					end else if (byte_pos < 8) begin
						hdr_height = {hdr_height[22:0], b};
					end else if (byte_pos < 13) begin
						hdr_bytes[(byte_pos - 8) * 8 +: 8] =
							hdr_bytes[(byte_pos - 8) * 8 +: 8] | b;
					end
				end else if (chunk_tag == pcp_pkg::TAG_IDAT) begin
					r.data.data_byte = b;
					produced = 1'b1;
				end
				byte_pos++;
				if (byte_pos >= chunk_len) begin
					byte_pos = 0;
					parse_phase = PH_CRC;
				end
			end
			PH_CRC: begin
				byte_pos++;
				if (byte_pos >= 4) begin
					byte_pos = 0;
					parse_phase = PH_LEN;
					if (chunk_tag == pcp_pkg::TAG_IHDR) begin
						depth = {24'd0, hdr_bytes[7:0]};
						bpp = 0;
						if (hdr_bytes[15:8] == pcp_pkg::COLOR_RGB) begin
							bpp = (3 * depth) / 8;
						end else if (hdr_bytes[15:8] == pcp_pkg::COLOR_RGBA) begin
							bpp = (4 * depth) / 8;
						end
						r.kind = pcp_pkg::KIND_HEADER;
						r.data.image_width = hdr_width;
						r.data.image_height = hdr_height;
						r.data.sample_depth = hdr_bytes[7:0];
						r.data.color_code = hdr_bytes[15:8];
						r.data.compression_method = hdr_bytes[23:16];
						r.data.filter_method = hdr_bytes[31:24];
						r.data.interlace_method = hdr_bytes[39:32];
						r.data.bytes_per_pixel = bpp[6:0];
						produced = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		return produced;
	endfunction

	// offer one byte request, return at the edge that takes it; entered at a rising edge
	task automatic send_byte(input logic [7:0] value, input bit typed,
			input pcp_pkg::result_t want);
		int unsigned      gap;
		bit               ready_seen;
		pcp_pkg::result_t pred;
		bit               produced;
		sender_calm = (bytes_sent >= 350 && bytes_sent < 450);
		gap = pick_gap(sender_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		// tready is stable by the falling edge, so look there and step to the taking edge
		ready_seen = 1'b0;
		while (!ready_seen) begin
			@(negedge clk);
			ready_seen = s_tready;
			@(posedge clk);
		end
		bytes_sent++;
		produced = parse_byte(value, pred);
		if (typed) begin
			results_due.push_back(want);
		end else if (produced) begin
			results_due.push_back(pred);
		end
	endtask

	// hold requests back until every pending result has drained
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (results_due.size() != 0);
	endtask

	// one whole chunk: length, type, body, crc
	task automatic send_chunk(input logic [31:0] tag, input int unsigned length);
		logic [31:0] len32;
		logic [7:0]  value;
		int          i;
		len32 = length;
		for (i = 3; i >= 0; i--) begin
			send_byte(len32[i * 8 +: 8], 1'b0, '0);
		end
		for (i = 3; i >= 0; i--) begin
			send_byte(tag[i * 8 +: 8], 1'b0, '0);
		end
		for (i = 0; i < int'(length); i++) begin
			value = 8'($urandom_range(0, 255));
			// steer depth and colour type so that bytes per pixel is often nonzero
			if (tag == pcp_pkg::TAG_IHDR && i == 8) begin
				case ($urandom_range(5))
					0: value = 8'd1;
					1: value = 8'd2;
					2: value = 8'd8;
					3: value = 8'd16;
					4: value = 8'd255;
					default: begin
					end
				endcase
			end else if (tag == pcp_pkg::TAG_IHDR && i == 9) begin
				case ($urandom_range(5))
					0: value = 8'd0;
					1: value = pcp_pkg::COLOR_RGB;
					2: value = pcp_pkg::COLOR_RGBA;
					3: value = 8'd3;
					4: value = 8'd4;
					default: begin
					end
				endcase
			end
			send_byte(value, 1'b0, '0);
		end
		for (i = 0; i < 4; i++) begin
			send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
		end
	endtask

	task automatic add_row(input logic [7:0] value, input bit typed,
			input pcp_pkg::result_t want);
		stim_row_t row;
		row.value = value;
		row.typed = typed;
		row.want = want;
		directed.push_back(row);
	endtask

	// result side: random stalls, with a calm window every so often
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_cycles++;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = pick_gap(((rx_cycles / 2000) % 4) == 1);
				m_tready <= (stall_left == 0);
				if (stall_left > 0) begin
					stall_left--;
				end
			end
		end
	end

	// check each taken result against the oldest pending one
	always @(negedge clk) begin
		pcp_pkg::result_t got;
		pcp_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = pcp_pkg::result_kind_t'(m_tuser);
			got.data = m_tdata[116:0];
			if (m_tuser < 3'd5) begin
				kind_seen[m_tuser]++;
			end
			if (results_due.size() == 0) begin
				if (bad_results < MAX_REPORTS) begin
					$display("unexpected result at %0t: %s", $time, fmt_result(got));
				end
				bad_results++;
			end else begin
				want = results_due.pop_front();
				if (got.kind != want.kind
						|| got.data.data_byte != want.data.data_byte
						|| got.data.image_width != want.data.image_width
						|| got.data.image_height != want.data.image_height
						|| got.data.sample_depth != want.data.sample_depth
						|| got.data.color_code != want.data.color_code
						|| got.data.compression_method != want.data.compression_method
						|| got.data.filter_method != want.data.filter_method
						|| got.data.interlace_method != want.data.interlace_method
						|| got.data.bytes_per_pixel != want.data.bytes_per_pixel) begin
					if (bad_results < MAX_REPORTS) begin
						$display("mismatch at %0t", $time);
						$display("  expected %s", fmt_result(want));
						$display("  actual   %s", fmt_result(got));
					end
					bad_results++;
				end
			end
		end
	end

	initial begin
		#(64'd8_000_000);
		$display("timeout with %0d results pending", results_due.size());
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		pcp_pkg::result_t hdr_want;
		int unsigned      r;
		int unsigned      length;
		int unsigned      next_drain;
		int unsigned      wait_cycles;
		int               k;
		logic [31:0]      tag;

		parse_phase = PH_SIG;
		sig_index = 3'd0;
		byte_pos = 0;
		chunk_len = '0;
		chunk_tag = '0;
		hdr_width = '0;
		hdr_height = '0;
		hdr_bytes = '0;

		// directed: valid signature, then a short ihdr with extreme width and height
		add_row(8'd137, 1'b0, '0);
		add_row(8'd80, 1'b0, '0);
		add_row(8'd78, 1'b0, '0);
		add_row(8'd71, 1'b0, '0);
		add_row(8'd13, 1'b0, '0);
		add_row(8'd10, 1'b0, '0);
		add_row(8'd26, 1'b0, '0);
		add_row(8'd10, 1'b0, '0);
		add_row(8'h00, 1'b0, '0);
		add_row(8'h00, 1'b0, '0);
		add_row(8'h00, 1'b0, '0);
		add_row(8'h0A, 1'b0, '0);
		add_row(pcp_pkg::TAG_IHDR[31:24], 1'b0, '0);
		add_row(pcp_pkg::TAG_IHDR[23:16], 1'b0, '0);
		add_row(pcp_pkg::TAG_IHDR[15:8], 1'b0, '0);
		add_row(pcp_pkg::TAG_IHDR[7:0], 1'b0, '0);
		add_row(8'hFF, 1'b0, '0);
		add_row(8'hFF, 1'b0, '0);
		add_row(8'hFF, 1'b0, '0);
		add_row(8'hFF, 1'b0, '0);
		add_row(8'h80, 1'b0, '0);
		add_row(8'h00, 1'b0, '0);
		add_row(8'h00, 1'b0, '0);
		add_row(8'h00, 1'b0, '0);
		add_row(8'd16, 1'b0, '0);
		add_row(pcp_pkg::COLOR_RGBA, 1'b0, '0);
		add_row(8'h5A, 1'b0, '0);
		add_row(8'hA5, 1'b0, '0);
		add_row(8'h00, 1'b0, '0);
		// top bits of width and height dropped, missing trailing bytes read as zero
		hdr_want = '0;
		hdr_want.kind = pcp_pkg::KIND_HEADER;
		hdr_want.data.image_width = 31'h7FFF_FFFF;
		hdr_want.data.image_height = 31'h0;
		hdr_want.data.sample_depth = 8'd16;
		hdr_want.data.color_code = pcp_pkg::COLOR_RGBA;
		hdr_want.data.bytes_per_pixel = 7'd8;
		add_row(8'hFF, 1'b1, hdr_want);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_byte(directed[i].value, directed[i].typed, directed[i].want);
		end

		// random: well-formed chunks with random content and some look-alike tags
		next_drain = bytes_sent + 250;
		while (bytes_sent < directed.size() + RANDOM_BYTES) begin
			if (bytes_sent >= next_drain) begin
				drain_results();
				next_drain = bytes_sent + 250;
			end
			r = $urandom_range(99);
			if (r < 50) begin
				tag = pcp_pkg::TAG_IDAT;
				length = ($urandom_range(19) == 0) ? $urandom_range(200, 300)
					: $urandom_range(0, 24);
			end else if (r < 70) begin
				tag = pcp_pkg::TAG_IHDR;
				length = ($urandom_range(9) < 7) ? 13 : $urandom_range(0, 20);
			end else if (r < 85) begin
				tag = $urandom;
				length = $urandom_range(0, 12);
			end else begin
				// one bit away from a known tag
				case ($urandom_range(2))
					0: tag = pcp_pkg::TAG_IHDR;
					1: tag = pcp_pkg::TAG_IDAT;
					default: tag = pcp_pkg::TAG_IEND;
				endcase
				tag = tag ^ (32'd1 << $urandom_range(31));
				length = $urandom_range(0, 12);
			end
			send_chunk(tag, length);
		end

		// finish the stream with an end chunk or a length that is too large
		if ($urandom_range(2) == 0) begin
			ended_by_error = 1'b1;
			send_byte(8'($urandom_range(128, 255)), 1'b0, '0);
		end else begin
			length = $urandom_range(0, 3);
			for (k = 3; k >= 0; k--) begin
				send_byte(length[k * 8 +: 8], 1'b0, '0);
			end
			for (k = 3; k >= 0; k--) begin
				send_byte(pcp_pkg::TAG_IEND[k * 8 +: 8], 1'b0, '0);
			end
		end
		// trailing bytes are swallowed without results
		repeat (16) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);

		s_tvalid <= 1'b0;
		wait_cycles = 0;
		while (results_due.size() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (results_due.size() != 0) begin
			$display("%0d results never arrived", results_due.size());
			bad_results += results_due.size();
		end
		repeat (8) @(posedge clk);

		$display("run fed %0d bytes: %0d data, %0d header, %0d end results",
			bytes_sent, kind_seen[pcp_pkg::KIND_DATA], kind_seen[pcp_pkg::KIND_HEADER],
			kind_seen[pcp_pkg::KIND_END]);
		$display("stream closed by %s, %0d bad results",
			ended_by_error ? "an oversized length" : "an end chunk", bad_results);
		if (bad_results == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ png_chunk_parser_top.f @@
rtl/pcp_pkg.sv
rtl/png_chunk_parser_top.sv
rtl/pcp_checker.sv
verif/tb.sv
